@@ sv/fwjs_pkg.sv @@
// fwjs_pkg: shared types and constants for the fifo window job scheduler
// no dependencies; imported by fwjs_regs, fifo_window_job_scheduler and its testbench
package fwjs_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned IN_DAY_W = 16;
  localparam int unsigned OUT_DAY_W = 16;
  localparam int unsigned ID_W = 11;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  localparam logic [APB_ADDR_W-3:0] REG_DAY_LIMIT = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INC   = 5'b00010,
    S_CHK   = 5'b00100,
    S_ADMIT = 5'b01000,
    S_DROP  = 5'b10000
  } state_e;

endpackage

@@ sv/fwjs_regs.sv @@
// fwjs_regs: apb configuration register block holding the day limit
// depends on fwjs_pkg
module fwjs_regs #(
  parameter int unsigned DAY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fwjs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fwjs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fwjs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [DAY_BITS-1:0]                 day_limit_o
);
  import fwjs_pkg::*;

  logic [DAY_BITS-1:0] day_limit_q, day_limit_d;
  logic [31:0]         wdata_ext;
  logic [31:0]         rdata_ext;
  logic                sel_limit;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[APB_ADDR_W-1:2] == REG_DAY_LIMIT);
  assign wdata_ext = {16'b0, pwdata[15:0]};
  assign rdata_ext = 32'(day_limit_q);

  always_comb begin
    day_limit_d = day_limit_q;
    if (psel && penable && pwrite && sel_limit) begin
      day_limit_d = wdata_ext[DAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_limit_q <= DAY_BITS'(32'h0000_FFFF);
    end else begin
      day_limit_q <= day_limit_d;
    end
  end

  assign prdata      = sel_limit ? APB_DATA_W'(rdata_ext) : '0;
  assign day_limit_o = day_limit_q;

endmodule

@@ sv/fifo_window_job_scheduler.sv @@
// fifo_window_job_scheduler: top level, sequencer with one shared comparator over job tables
// load, clear and unused actions: result strobe in the cycle after accept, busy stays low
// tick: result strobe after states inc, check, admit, drop (inc or check may end early),
//   one table entry per cycle through the shared comparator and one memory read port each
// results cannot be stalled; reset empties the table, zeroes the day, day limit 65535
// depends on fwjs_pkg and fwjs_regs
module fifo_window_job_scheduler #(
  parameter int unsigned MAX_JOBS = 1024,
  parameter int unsigned DAY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [fwjs_pkg::ACTION_W-1:0]       action_i,
  input  logic [fwjs_pkg::IN_DAY_W-1:0]       start_day_i,
  input  logic [fwjs_pkg::IN_DAY_W-1:0]       end_day_i,
  output logic                                done_o,
  output logic                                served_o,
  output logic [fwjs_pkg::ID_W-1:0]           job_id_o,
  output logic [fwjs_pkg::OUT_DAY_W-1:0]      day_o,
  output logic                                load_rejected_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fwjs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fwjs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fwjs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import fwjs_pkg::*;

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);

  state_e state_q, state_d;

  logic [CNT_W-1:0]    load_q, load_d;
  logic [CNT_W-1:0]    admit_q, admit_d;
  logic [CNT_W-1:0]    head_q, head_d;
  logic [DAY_BITS-1:0] day_q, day_d;

  logic [DAY_BITS-1:0] start_mem [MAX_JOBS];
  logic [DAY_BITS-1:0] end_mem [MAX_JOBS];
  logic [DAY_BITS-1:0] start_rd_q;
  logic [DAY_BITS-1:0] end_rd_q;

  logic                done_q, done_d;
  logic                served_q, served_d;
  logic [ID_W-1:0]     job_id_q, job_id_d;
  logic [OUT_DAY_W-1:0] day_out_q, day_out_d;
  logic                rejected_q, rejected_d;

  logic [DAY_BITS-1:0] day_limit;
  logic [DAY_BITS-1:0] cmp_a, cmp_b;
  logic                cmp_gt;
  logic                accept;
  logic                table_full;
  logic                wr_en;
  logic [31:0]         start_ext, end_ext;
  logic [31:0]         id_ext;
  logic [31:0]         day_ext;
  logic [OUT_DAY_W-1:0] day_out;

  fwjs_regs #(
    .DAY_BITS (DAY_BITS)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .day_limit_o (day_limit)
  );

  assign accept     = start && state_q == S_IDLE;
  assign busy       = state_q != S_IDLE;
  assign table_full = load_q >= CNT_W'(MAX_JOBS);
  assign wr_en      = accept && action_e'(action_i) == ACT_LOAD && !table_full;
  assign start_ext  = {16'b0, start_day_i};
  assign end_ext    = {16'b0, end_day_i};
  assign id_ext     = 32'(head_q) + 32'd1;
  assign day_ext    = 32'(day_q);
  assign day_out    = day_ext[OUT_DAY_W-1:0];

  // shared comparator, operands steered by state
  always_comb begin
    unique case (state_q)
      S_ADMIT: begin
        cmp_a = start_rd_q;
        cmp_b = day_q;
      end
      S_DROP: begin
        cmp_a = day_q;
        cmp_b = end_rd_q;
      end
      default: begin
        cmp_a = day_q;
        cmp_b = day_limit;
      end
    endcase
  end
  assign cmp_gt = cmp_a > cmp_b;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[load_q[IDX_W-1:0]] <= start_ext[DAY_BITS-1:0];
      end_mem[load_q[IDX_W-1:0]]   <= end_ext[DAY_BITS-1:0];
    end
    start_rd_q <= start_mem[admit_d[IDX_W-1:0]];
    end_rd_q   <= end_mem[head_d[IDX_W-1:0]];
  end

  always_comb begin
    state_d    = state_q;
    load_d     = load_q;
    admit_d    = admit_q;
    head_d     = head_q;
    day_d      = day_q;
    done_d     = 1'b0;
    served_d   = 1'b0;
    job_id_d   = '0;
    day_out_d  = '0;
    rejected_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (action_e'(action_i))
            ACT_LOAD: begin
              done_d = 1'b1;
              if (table_full) begin
                rejected_d = 1'b1;
              end else begin
                load_d = load_q + CNT_W'(1);
              end
            end
            ACT_TICK: state_d = S_INC;
            ACT_CLEAR: begin
              done_d  = 1'b1;
              load_d  = '0;
              admit_d = '0;
              head_d  = '0;
              day_d   = '0;
            end
            ACT_NONE: done_d = 1'b1;
          endcase
        end
      end
      S_INC: begin
        if (day_q == {DAY_BITS{1'b1}}) begin
          done_d    = 1'b1;
          day_out_d = day_out;
          state_d   = S_IDLE;
        end else begin
          day_d   = day_q + DAY_BITS'(1);
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (cmp_gt) begin
          done_d    = 1'b1;
          day_out_d = day_out;
          state_d   = S_IDLE;
        end else begin
          state_d = S_ADMIT;
        end
      end
      S_ADMIT: begin
        if (admit_q < load_q && !cmp_gt) begin
          admit_d = admit_q + CNT_W'(1);
        end else begin
          state_d = S_DROP;
        end
      end
      S_DROP: begin
        if (head_q < admit_q && cmp_gt) begin
          head_d = head_q + CNT_W'(1);
        end else begin
          done_d    = 1'b1;
          day_out_d = day_out;
          state_d   = S_IDLE;
          if (head_q < admit_q) begin
            served_d = 1'b1;
            job_id_d = id_ext[ID_W-1:0];
            head_d   = head_q + CNT_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      load_q  <= '0;
      admit_q <= '0;
      head_q  <= '0;
      day_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      admit_q <= admit_d;
      head_q  <= head_d;
      day_q   <= day_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    served_q   <= served_d;
    job_id_q   <= job_id_d;
    day_out_q  <= day_out_d;
    rejected_q <= rejected_d;
  end

  assign done_o          = done_q;
  assign served_o        = served_q;
  assign job_id_o        = job_id_q;
  assign day_o           = day_out_q;
  assign load_rejected_o = rejected_q;

endmodule

@@ verif/fifo_window_job_scheduler_tb.sv @@
// fifo_window_job_scheduler_tb: self-checking testbench for the fifo window job scheduler
// drives command transactions and the apb register port, predicts each result in a scoreboard
// depends on fwjs_pkg and fifo_window_job_scheduler
module fifo_window_job_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwjs_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam logic [IN_DAY_W-1:0] DAY_MAX = '1;

  typedef struct packed {
    logic                 served;
    logic [ID_W-1:0]      job_id;
    logic [OUT_DAY_W-1:0] day;
    logic                 rejected;
  } sched_result_t;

  class sched_scoreboard;
    logic [IN_DAY_W-1:0] start_days[TABLE_DEPTH];
    logic [IN_DAY_W-1:0] end_days[TABLE_DEPTH];
    int unsigned jobs_loaded;
    int unsigned admitted;
    int unsigned head;
    logic [IN_DAY_W-1:0] today;
    logic [IN_DAY_W-1:0] day_limit;
    sched_result_t pending[$];
    int unsigned mismatches;

    function new();
      jobs_loaded = 0;
      admitted = 0;
      head = 0;
      today = '0;
      day_limit = DAY_MAX;
      mismatches = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task note_transaction(input action_e act, input logic [IN_DAY_W-1:0] s,
                          input logic [IN_DAY_W-1:0] e);
      sched_result_t res;
      res = '0;
      case (act)
        ACT_LOAD: begin
          if (jobs_loaded >= TABLE_DEPTH) begin
            res.rejected = 1'b1;
          end else begin
            start_days[jobs_loaded] = s;
            end_days[jobs_loaded] = e;
            jobs_loaded++;
          end
        end
        ACT_CLEAR: begin
          jobs_loaded = 0;
          admitted = 0;
          head = 0;
          today = '0;
        end
        ACT_TICK: begin
          if (today == DAY_MAX) begin
            res.day = today;
          end else begin
            today++;
            res.day = today;
            if (today <= day_limit) begin
              while (admitted < jobs_loaded && start_days[admitted] <= today) admitted++;
              while (head < admitted && end_days[head] < today) head++;
              if (head < admitted) begin
                res.served = 1'b1;
                res.job_id = ID_W'(head + 1);
                head++;
              end
            end
          end
        end
        default: ;
      endcase
      pending.insert(pending.size(), res);
    endtask

    task check_result(input sched_result_t got);
      sched_result_t want;
      if (pending.size() == 0) begin
        report("result with no transaction pending");
      end else begin
        want = pending.pop_front();
        if (got.served !== want.served)
          report($sformatf("served %b, expected %b", got.served, want.served));
        if (got.job_id !== want.job_id)
          report($sformatf("job_id %0d, expected %0d", got.job_id, want.job_id));
        if (got.day !== want.day)
          report($sformatf("day %0d, expected %0d", got.day, want.day));
        if (got.rejected !== want.rejected)
          report($sformatf("load_rejected %b, expected %b", got.rejected, want.rejected));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACTION_W-1:0]    action_i = '0;
  logic [IN_DAY_W-1:0]    start_day_i = '0;
  logic [IN_DAY_W-1:0]    end_day_i = '0;
  logic                   done_o;
  logic                   served_o;
  logic [ID_W-1:0]        job_id_o;
  logic [OUT_DAY_W-1:0]   day_o;
  logic                   load_rejected_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  sched_scoreboard sb;
  bit idle_gaps;

  fifo_window_job_scheduler uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send(input action_e act, input logic [IN_DAY_W-1:0] s,
                      input logic [IN_DAY_W-1:0] e);
    int unsigned gap;
    gap = idle_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    start_day_i <= s;
    end_day_i <= e;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_transaction(act, s, e);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_DAY_LIMIT, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_day_limit(input logic [IN_DAY_W-1:0] limit);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(limit))
      sb.report($sformatf("day_limit reads %0d, expected %0d", rd, limit));
  endtask

  task automatic set_day_limit(input logic [IN_DAY_W-1:0] limit);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, APB_DATA_W'(limit), rd);
    sb.day_limit = limit;
    check_day_limit(limit);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      sb.check_result(sched_result_t'({served_o, job_id_o, day_o, load_rejected_o}));
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && busy === 1'b0) || done_o === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned items;
    int unsigned loads;
    int unsigned phase_len;
    int unsigned pick;
    int unsigned ticks;
    int s;
    int e;
    int last_start;
    logic [IN_DAY_W-1:0] limit;

    sb = new();
    idle_gaps = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    check_day_limit(DAY_MAX);
    idle_gaps = 1'b1;
    send(ACT_TICK, '0, '0);
    send(ACT_NONE, '1, '1);
    send(ACT_LOAD, 16'd1, 16'd1);
    send(ACT_LOAD, 16'd1, DAY_MAX);
    send(ACT_LOAD, 16'd2, 16'd1);
    send(ACT_LOAD, 16'd3, 16'd3);
    send(ACT_LOAD, DAY_MAX, DAY_MAX);
    send(ACT_LOAD, 16'd2, 16'd9);
    repeat (3) send(ACT_TICK, '1, '1);
    send(ACT_CLEAR, '1, '1);
    send(ACT_LOAD, 16'd1, 16'd2);
    send(ACT_LOAD, 16'd1, 16'd2);
    drain();
    set_day_limit(16'd1);
    repeat (2) send(ACT_TICK, '0, '0);
    drain();
    set_day_limit(DAY_MAX);
    send(ACT_TICK, '0, '0);
    send(ACT_NONE, '0, '0);

    // fill the job table past capacity
    drain();
    set_day_limit(16'($urandom_range(200, 65535)));
    send(ACT_CLEAR, 16'($urandom), 16'($urandom));
    last_start = 1;
    loads = 0;
    while (loads < TABLE_DEPTH + 6) begin
      if (loads % 128 == 0) idle_gaps = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        send(ACT_TICK, 16'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(0, 7) == 0) last_start++;
        s = last_start;
        e = s + $urandom_range(0, 200);
        send(ACT_LOAD, 16'(s), 16'(e));
        loads++;
      end
    end
    repeat (4) send(ACT_TICK, 16'($urandom), 16'($urandom));

    // random phases of mostly ordered loads around the current day
    items = 0;
    while (items < 120) begin
      idle_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0: limit = 16'd1;
          1: limit = DAY_MAX;
          2: limit = 16'($urandom_range(2, 40));
          default: limit = 16'($urandom_range(1, 65535));
        endcase
        set_day_limit(limit);
      end
      send(ACT_CLEAR, 16'($urandom), 16'($urandom));
      last_start = 1;
      ticks = 0;
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send(ACT_TICK, 16'($urandom), 16'($urandom));
          ticks++;
        end else if (pick < 88) begin
          s = ticks + $urandom_range(0, 6);
          if (s < last_start) s = last_start;
          e = (pick < 50 && s > 1) ? s - 1 : s + $urandom_range(0, 8);
          last_start = s;
          send(ACT_LOAD, 16'(s), 16'(e));
        end else if (pick < 94) begin
          send(ACT_LOAD, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        end else if (pick < 97) begin
          send(ACT_NONE, 16'($urandom), 16'($urandom));
        end else begin
          send(ACT_CLEAR, 16'($urandom), 16'($urandom));
          last_start = 1;
          ticks = 0;
        end
        items++;
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fwjs_pkg.sv
sv/fwjs_regs.sv
sv/fifo_window_job_scheduler.sv
verif/fifo_window_job_scheduler_tb.sv
